### rtl/fnb_pkg.sv
package fnb_pkg;

  // Quotient bits of ci^2 * 2^30 / |c|^2, which never exceeds 2^30
  localparam int QUO_BITS   = 31;
  // Root bits of that quotient, which never exceeds 2^15
  localparam int ROOT_BITS  = 16;
  localparam int RAD_WIDTH  = 2 * ROOT_BITS;
  localparam int NORM_WIDTH = 16;
  localparam int AXES       = 3;

  // Multiply schedule: six cross-product terms, then three squares
  localparam logic [3:0] SQ_FIRST = 4'd6;
  localparam logic [3:0] MUL_LAST = 4'd8;

  localparam logic [2:0] VERTS_TRI  = 3'd3;
  localparam logic [2:0] VERTS_QUAD = 3'd4;

  typedef struct packed {
    logic [1:0] a_axis;
    logic [1:0] b_axis;
    logic       sub;
  } cross_pick_t;

  // Operand axes of each cross-product term; odd terms are subtracted
  function automatic cross_pick_t cross_pick(input logic [2:0] term);
    cross_pick_t p;
    case (term)
      3'd0:    p = '{a_axis: 2'd1, b_axis: 2'd2, sub: 1'b0};
      3'd1:    p = '{a_axis: 2'd2, b_axis: 2'd1, sub: 1'b1};
      3'd2:    p = '{a_axis: 2'd2, b_axis: 2'd0, sub: 1'b0};
      3'd3:    p = '{a_axis: 2'd0, b_axis: 2'd2, sub: 1'b1};
      3'd4:    p = '{a_axis: 2'd0, b_axis: 2'd1, sub: 1'b0};
      3'd5:    p = '{a_axis: 2'd1, b_axis: 2'd0, sub: 1'b1};
      default: p = '{a_axis: 2'd0, b_axis: 2'd0, sub: 1'b0};
    endcase
    return p;
  endfunction

endpackage

### rtl/fnb_mul.sv
module fnb_mul #(
  parameter int AW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic            done,
  output logic [2*AW-1:0] p
);

  localparam int CNTW = $clog2(AW + 1);

  logic [AW-1:0]   a_r;
  logic [2*AW-1:0] prod_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [AW:0]     upper;

  // Add the multiplicand under the current multiplier bit
  assign upper = {1'b0, prod_r[2*AW-1:AW]} + {1'b0, (prod_r[0] ? a_r : {AW{1'b0}})};

  // Shift one multiplier bit out per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        prod_r <= {{AW{1'b0}}, b};
        cnt_r  <= CNTW'(AW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        prod_r <= {upper, prod_r[AW-1:1]};
        cnt_r  <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = prod_r;

endmodule

### rtl/fnb_div.sv
module fnb_div #(
  parameter int NW = 8,
  parameter int QB = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] n,
  input  logic [NW-1:0] d,
  output logic          done,
  output logic [QB-1:0] q
);

  localparam int CNTW = $clog2(QB + 1);

  logic [NW:0]     rem_r;
  logic [NW-1:0]   d_r;
  logic [QB-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            ge;
  logic [NW:0]     diff;
  logic [NW:0]     r1;

  // Trial subtract of the divisor from the partial remainder
  assign ge   = rem_r >= {1'b0, d_r};
  assign diff = rem_r - {1'b0, d_r};
  assign r1   = ge ? diff : rem_r;

  // One quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= {1'b0, n};
        d_r    <= d;
        q_r    <= '0;
        cnt_r  <= CNTW'(QB);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= {r1[NW-1:0], 1'b0};
        q_r   <= {q_r[QB-2:0], ge};
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

### rtl/fnb_isqrt.sv
module fnb_isqrt #(
  parameter int RB = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RB-1:0] x,
  output logic            done,
  output logic [RB-1:0]   s
);

  localparam int CNTW = $clog2(RB + 1);

  logic [2*RB-1:0] x_r;
  logic [RB+1:0]   rem_r;
  logic [RB-1:0]   root_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RB+1:0]   rem_sh;
  logic [RB+1:0]   trial;
  logic            ge;

  // Bring down the next two radicand bits and try 4r+1
  assign rem_sh = {rem_r[RB-1:0], x_r[2*RB-1:2*RB-2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  // One root bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNTW'(RB);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r    <= {x_r[2*RB-3:0], 2'b00};
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[RB-2:0], ge};
        cnt_r  <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign s    = root_r;

endmodule

### rtl/face_normal_and_bounds_top.sv
// Face normal and running bounds. Each word carries a triangle or quad of signed Q16.16
// vertices; the block widens a running bounding box over the vertices in use, forms the
// exact cross product (v1-v0)x(vL-v0) and returns its Q1.14 unit normal, rounded to
// nearest, with a degenerate flag and a saturating count of non-degenerate elements.
// One element is worked on at a time, and a degenerate element skips the divides and
// roots. The nine products of an element go through one shared shift-add multiplier,
// which retires one multiplier bit per cycle (2*COORD_WIDTH+1 bits per product) and is
// followed by a bit-serial divider and square root per axis. A finished result waits in
// an output register, so the next element is taken while it is still held; the block
// only stalls when a new result is ready before the previous one has been taken. The
// vertex count register is to be written through the cfg port only while the block is
// idle; the block itself does not enforce this. Values other than 3 or 4 are ignored.
module face_normal_and_bounds_top import fnb_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int TALLY_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_element_vertices,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_v0_x,
  input  logic signed [COORD_WIDTH-1:0] in_v0_y,
  input  logic signed [COORD_WIDTH-1:0] in_v0_z,
  input  logic signed [COORD_WIDTH-1:0] in_v1_x,
  input  logic signed [COORD_WIDTH-1:0] in_v1_y,
  input  logic signed [COORD_WIDTH-1:0] in_v1_z,
  input  logic signed [COORD_WIDTH-1:0] in_v2_x,
  input  logic signed [COORD_WIDTH-1:0] in_v2_y,
  input  logic signed [COORD_WIDTH-1:0] in_v2_z,
  input  logic signed [COORD_WIDTH-1:0] in_v3_x,
  input  logic signed [COORD_WIDTH-1:0] in_v3_y,
  input  logic signed [COORD_WIDTH-1:0] in_v3_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [NORM_WIDTH-1:0]  out_normal_x,
  output logic signed [NORM_WIDTH-1:0]  out_normal_y,
  output logic signed [NORM_WIDTH-1:0]  out_normal_z,
  output logic                          out_degenerate,
  output logic [TALLY_WIDTH-1:0]        out_kept_elements,
  output logic signed [COORD_WIDTH-1:0] out_box_min_x,
  output logic signed [COORD_WIDTH-1:0] out_box_min_y,
  output logic signed [COORD_WIDTH-1:0] out_box_min_z,
  output logic signed [COORD_WIDTH-1:0] out_box_max_x,
  output logic signed [COORD_WIDTH-1:0] out_box_max_y,
  output logic signed [COORD_WIDTH-1:0] out_box_max_z
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;       // edge vector component
  localparam int XW = 2 * W + 2;   // signed cross-product component
  localparam int MW = XW - 1;      // its magnitude, and the multiplier width
  localparam int SW = 2 * MW;      // multiplier product
  localparam int LW = SW + 2;      // squared length

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BOUND = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_ROOT  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r;

  logic signed [W-1:0]          vin [4][AXES];
  logic signed [W-1:0]          v_r [4][AXES];
  logic signed [DW-1:0]         d1_r [AXES];
  logic signed [DW-1:0]         d2_r [AXES];
  logic signed [XW-1:0]         c_r [AXES];
  logic [SW-1:0]                sq_r [AXES];
  logic [LW-1:0]                len_r;
  logic signed [W-1:0]          low_r [AXES];
  logic signed [W-1:0]          high_r [AXES];
  logic signed [NORM_WIDTH-1:0] norm_r [AXES];
  logic signed [NORM_WIDTH-1:0] on_r [AXES];
  logic signed [W-1:0]          olo_r [AXES];
  logic signed [W-1:0]          ohi_r [AXES];
  logic                         degen_r;
  logic                         odegen_r;
  logic [TALLY_WIDTH-1:0]       tally_r;
  logic [TALLY_WIDTH-1:0]       tally_upd;
  logic                         quad_r;
  logic                         launch_r;
  logic                         out_valid_r;
  logic [1:0]                   vcnt_r;
  logic [3:0]                   idx_r;
  logic [1:0]                   ax_r;

  cross_pick_t                  pick;
  logic signed [DW-1:0]         da;
  logic signed [DW-1:0]         db;
  logic [DW-1:0]                da_mag;
  logic [DW-1:0]                db_mag;
  logic [1:0]                   sq_ax;
  logic [1:0]                   cross_ax;
  logic signed [XW-1:0]         c_sel;
  logic [XW-1:0]                c_mag;
  logic [MW-1:0]                mul_a;
  logic [MW-1:0]                mul_b;
  logic                         mul_done;
  logic [SW-1:0]                mul_p;
  logic signed [XW-1:0]         term;
  logic signed [XW-1:0]         tval;
  logic                         tneg;
  logic [LW-1:0]                len_sum;
  logic                         div_done;
  logic [QUO_BITS-1:0]          div_q;
  logic                         root_done;
  logic [ROOT_BITS-1:0]         root_s;
  logic [ROOT_BITS:0]           nm_sum;
  logic [NORM_WIDTH-1:0]        nmag;
  logic [1:0]                   last_vtx;

  assign vin[0][0] = in_v0_x;
  assign vin[0][1] = in_v0_y;
  assign vin[0][2] = in_v0_z;
  assign vin[1][0] = in_v1_x;
  assign vin[1][1] = in_v1_y;
  assign vin[1][2] = in_v1_z;
  assign vin[2][0] = in_v2_x;
  assign vin[2][1] = in_v2_y;
  assign vin[2][2] = in_v2_z;
  assign vin[3][0] = in_v3_x;
  assign vin[3][1] = in_v3_y;
  assign vin[3][2] = in_v3_z;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign last_vtx  = quad_r ? 2'd3 : 2'd2;

  // Pick the operands of the current multiply
  always_comb begin
    pick     = cross_pick(idx_r[2:0]);
    da       = d1_r[pick.a_axis];
    db       = d2_r[pick.b_axis];
    da_mag   = da[DW-1] ? -da : da;
    db_mag   = db[DW-1] ? -db : db;
    sq_ax    = 2'(idx_r - SQ_FIRST);
    cross_ax = idx_r[2:1];
    c_sel    = c_r[sq_ax];
    c_mag    = c_sel[XW-1] ? -c_sel : c_sel;
    if (idx_r < SQ_FIRST) begin
      mul_a = MW'(da_mag);
      mul_b = MW'(db_mag);
    end else begin
      mul_a = c_mag[MW-1:0];
      mul_b = c_mag[MW-1:0];
    end
    term    = mul_p[XW-1:0];
    tneg    = da[DW-1] ^ db[DW-1] ^ pick.sub;
    tval    = tneg ? -term : term;
    len_sum = (idx_r == SQ_FIRST) ? LW'(mul_p) : len_r + LW'(mul_p);
  end

  // Round the root to the nearest odd bound: q = (s + 1) / 2
  assign nm_sum = {1'b0, root_s} + (ROOT_BITS + 1)'(1);
  assign nmag   = NORM_WIDTH'(nm_sum[ROOT_BITS:1]);

  // Saturating count after this element
  assign tally_upd = (!degen_r && !(&tally_r)) ? tally_r + TALLY_WIDTH'(1) : tally_r;

  fnb_mul #(.AW(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch_r && state_r == S_MUL),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  fnb_div #(.NW(LW), .QB(QUO_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch_r && state_r == S_DIV),
    .n     (LW'(sq_r[ax_r])),
    .d     (len_r),
    .done  (div_done),
    .q     (div_q)
  );

  fnb_isqrt #(.RB(ROOT_BITS)) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (launch_r && state_r == S_ROOT),
    .x     (RAD_WIDTH'(div_q)),
    .done  (root_done),
    .s     (root_s)
  );

  // Sequence one element through bounds, multiplies, divides and roots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tally_r     <= '0;
      quad_r      <= 1'b0;
      for (int j = 0; j < AXES; j++) begin
        low_r[j]  <= {1'b0, {(W-1){1'b1}}};
        high_r[j] <= {1'b1, {(W-1){1'b0}}};
      end
    end else begin
      launch_r <= 1'b0;

      // Take the vertex count
      if (cfg_valid && cfg_element_vertices inside {VERTS_TRI, VERTS_QUAD}) begin
        quad_r <= (cfg_element_vertices == VERTS_QUAD);
      end

      // Drop the result word once taken
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            v_r <= vin;
            for (int j = 0; j < AXES; j++) begin
              d1_r[j] <= DW'(vin[1][j]) - DW'(vin[0][j]);
              d2_r[j] <= DW'(quad_r ? vin[3][j] : vin[2][j]) - DW'(vin[0][j]);
            end
            vcnt_r  <= 2'd0;
            state_r <= S_BOUND;
          end
        end

        S_BOUND: begin
          // Widen the box by one vertex a cycle
          for (int j = 0; j < AXES; j++) begin
            if (v_r[vcnt_r][j] < low_r[j]) low_r[j] <= v_r[vcnt_r][j];
            if (v_r[vcnt_r][j] > high_r[j]) high_r[j] <= v_r[vcnt_r][j];
          end
          if (vcnt_r == last_vtx) begin
            idx_r    <= 4'd0;
            launch_r <= 1'b1;
            state_r  <= S_MUL;
          end else begin
            vcnt_r <= vcnt_r + 2'd1;
          end
        end

        S_MUL: begin
          if (mul_done) begin
            if (idx_r < SQ_FIRST) begin
              c_r[cross_ax] <= idx_r[0] ? c_r[cross_ax] + tval : tval;
              idx_r         <= idx_r + 4'd1;
              launch_r      <= 1'b1;
            end else begin
              sq_r[sq_ax] <= mul_p;
              len_r       <= len_sum;
              if (idx_r == MUL_LAST) begin
                if (len_sum == '0) begin
                  degen_r <= 1'b1;
                  for (int j = 0; j < AXES; j++) norm_r[j] <= '0;
                  state_r <= S_OUT;
                end else begin
                  degen_r  <= 1'b0;
                  ax_r     <= 2'd0;
                  launch_r <= 1'b1;
                  state_r  <= S_DIV;
                end
              end else begin
                idx_r    <= idx_r + 4'd1;
                launch_r <= 1'b1;
              end
            end
          end
        end

        S_DIV: begin
          if (div_done) begin
            launch_r <= 1'b1;
            state_r  <= S_ROOT;
          end
        end

        S_ROOT: begin
          if (root_done) begin
            norm_r[ax_r] <= c_r[ax_r][XW-1] ? -nmag : nmag;
            if (ax_r == 2'd2) begin
              state_r <= S_OUT;
            end else begin
              ax_r     <= ax_r + 2'd1;
              launch_r <= 1'b1;
              state_r  <= S_DIV;
            end
          end
        end

        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ready) begin
            on_r        <= norm_r;
            olo_r       <= low_r;
            ohi_r       <= high_r;
            odegen_r    <= degen_r;
            tally_r     <= tally_upd;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_normal_x      = on_r[0];
  assign out_normal_y      = on_r[1];
  assign out_normal_z      = on_r[2];
  assign out_degenerate    = odegen_r;
  assign out_kept_elements = tally_r;
  assign out_box_min_x     = olo_r[0];
  assign out_box_min_y     = olo_r[1];
  assign out_box_min_z     = olo_r[2];
  assign out_box_max_x     = ohi_r[0];
  assign out_box_max_y     = ohi_r[1];
  assign out_box_max_z     = ohi_r[2];

endmodule

### tb/face_normal_and_bounds_checker.sv
`timescale 1ns / 1ps

module face_normal_and_bounds_checker import fnb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_element_vertices,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_v0_x,
  input  logic signed [31:0] in_v0_y,
  input  logic signed [31:0] in_v0_z,
  input  logic signed [31:0] in_v1_x,
  input  logic signed [31:0] in_v1_y,
  input  logic signed [31:0] in_v1_z,
  input  logic signed [31:0] in_v2_x,
  input  logic signed [31:0] in_v2_y,
  input  logic signed [31:0] in_v2_z,
  input  logic signed [31:0] in_v3_x,
  input  logic signed [31:0] in_v3_y,
  input  logic signed [31:0] in_v3_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_normal_x,
  input  logic signed [15:0] out_normal_y,
  input  logic signed [15:0] out_normal_z,
  input  logic               out_degenerate,
  input  logic [23:0]        out_kept_elements,
  input  logic signed [31:0] out_box_min_x,
  input  logic signed [31:0] out_box_min_y,
  input  logic signed [31:0] out_box_min_z,
  input  logic signed [31:0] out_box_max_x,
  input  logic signed [31:0] out_box_max_y,
  input  logic signed [31:0] out_box_max_z,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
    logic [23:0]        kept;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } face_word_t;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic [23:0]        kept_tally;
  logic [2:0]         verts_per_face;
  face_word_t         awaited_faces [$];

  // Widen the box, form the cross product and its rounded unit normal
  function automatic face_word_t face_result(input logic signed [31:0] pt [4][3]);
    face_word_t r;
    wide_t d1 [3], d2 [3], cr [3], mag [3], len2, rhs, lhs;
    int last, lo, hi, mid;
    last = (verts_per_face == VERTS_QUAD) ? 3 : 2;
    for (int i = 0; i <= last; i++)
      for (int j = 0; j < 3; j++) begin
        if (pt[i][j] < box_lo[j]) box_lo[j] = pt[i][j];
        if (pt[i][j] > box_hi[j]) box_hi[j] = pt[i][j];
      end
    for (int j = 0; j < 3; j++) begin
      d1[j] = wide_t'(pt[1][j]) - wide_t'(pt[0][j]);
      d2[j] = wide_t'(pt[last][j]) - wide_t'(pt[0][j]);
    end
    cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
    cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
    cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
    len2 = 0;
    for (int j = 0; j < 3; j++) begin
      mag[j] = (cr[j] < 0) ? -cr[j] : cr[j];
      len2 = len2 + mag[j] * mag[j];
    end
    r.degen = (len2 == 0);
    for (int j = 0; j < 3; j++) begin
      lo = 0;
      if (!r.degen) begin
        hi = 16384;
        rhs = (mag[j] * mag[j]) <<< 30;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          lhs = len2 * wide_t'((2 * mid - 1) * (2 * mid - 1));
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
      end
      if (cr[j] < 0) lo = -lo;
      case (j)
        0: r.nx = 16'(lo);
        1: r.ny = 16'(lo);
        default: r.nz = 16'(lo);
      endcase
    end
    if (!r.degen && kept_tally != '1) kept_tally = kept_tally + 1'b1;
    r.kept  = kept_tally;
    r.min_x = box_lo[0]; r.min_y = box_lo[1]; r.min_z = box_lo[2];
    r.max_x = box_hi[0]; r.max_y = box_hi[1]; r.max_z = box_hi[2];
    return r;
  endfunction

  function automatic int field_ok(string name, longint want, longint got);
    if (want == got) return 0;
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    logic signed [31:0] pt [4][3];
    face_word_t want;
    int bad;
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) begin
        box_lo[j] = 32'sh7fffffff;
        box_hi[j] = 32'sh80000000;
      end
      kept_tally     = '0;
      verts_per_face = VERTS_TRI;
      fail_count     = 0;
      awaited_faces.delete();
    end else begin
      // Compare a delivered word with the oldest awaited face
      if (out_valid && out_ready) begin
        if (awaited_faces.size() == 0) begin
          $display("%0t: unexpected result word, nothing awaited", $time);
          fail_count++;
        end else begin
          want = awaited_faces.pop_front();
          bad = field_ok("normal_x", want.nx, out_normal_x)
              + field_ok("normal_y", want.ny, out_normal_y)
              + field_ok("normal_z", want.nz, out_normal_z)
              + field_ok("degenerate", want.degen, out_degenerate)
              + field_ok("kept_elements", want.kept, out_kept_elements)
              + field_ok("box_min_x", want.min_x, out_box_min_x)
              + field_ok("box_min_y", want.min_y, out_box_min_y)
              + field_ok("box_min_z", want.min_z, out_box_min_z)
              + field_ok("box_max_x", want.max_x, out_box_max_x)
              + field_ok("box_max_y", want.max_y, out_box_max_y)
              + field_ok("box_max_z", want.max_z, out_box_max_z);
          if (bad != 0) fail_count++;
        end
      end
      // Apply a register write; out-of-range counts are dropped
      if (cfg_valid && cfg_ready)
        if (cfg_element_vertices == VERTS_TRI || cfg_element_vertices == VERTS_QUAD)
          verts_per_face = cfg_element_vertices;
      // Predict the result of an accepted element
      if (in_valid && in_ready) begin
        pt[0] = '{in_v0_x, in_v0_y, in_v0_z};
        pt[1] = '{in_v1_x, in_v1_y, in_v1_z};
        pt[2] = '{in_v2_x, in_v2_y, in_v2_z};
        pt[3] = '{in_v3_x, in_v3_y, in_v3_z};
        awaited_faces = {awaited_faces, face_result(pt)};
      end
    end
    pending = awaited_faces.size();
  end

  final begin
    if (awaited_faces.size() != 0)
      $display("%0t: %0d result words never arrived", $time, awaited_faces.size());
  end

endmodule

### tb/face_normal_and_bounds_top_tb.sv
`timescale 1ns / 1ps

module face_normal_and_bounds_top_tb import fnb_pkg::*;;

  localparam logic [2:0] VERTS_ZERO  = 3'd0;
  localparam logic [2:0] VERTS_FIVE  = 3'd5;
  localparam logic [2:0] VERTS_SEVEN = 3'd7;
  localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] C_MIN = 32'sh80000000;
  localparam int SETTLE_CYCLES = 1000;

  typedef enum logic [1:0] {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

  logic               clk, rst_n;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_element_vertices;
  logic               in_valid, in_ready;
  logic signed [31:0] in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z;
  logic signed [31:0] in_v2_x, in_v2_y, in_v2_z, in_v3_x, in_v3_y, in_v3_z;
  logic               out_valid, out_ready;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic               out_degenerate;
  logic [23:0]        out_kept_elements;
  logic signed [31:0] out_box_min_x, out_box_min_y, out_box_min_z;
  logic signed [31:0] out_box_max_x, out_box_max_y, out_box_max_z;
  int                 fail_count, pending;
  flow_t              flow;

  face_normal_and_bounds_top dut (.*);
  face_normal_and_bounds_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random when the phase asks for it
  always @(posedge clk)
    out_ready <= (flow == FLOW_RECV_STALLS) ? ($urandom_range(99) >= 55)
               : (flow == FLOW_BOTH) ? ($urandom_range(99) >= 10) : 1'b1;

  initial begin
    #100ms;
    $display("** face_normal_and_bounds_top: FAILED **");
    $finish;
  end

  // Offer one element and hold it until taken
  task automatic send_face(input logic signed [31:0] p [12]);
    int gap;
    gap = (flow == FLOW_SEND_GAPS) ? 55 : (flow == FLOW_BOTH) ? 10 : 0;
    if ($urandom_range(99) < gap) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z} <= {p[0], p[1], p[2], p[3], p[4], p[5]};
    {in_v2_x, in_v2_y, in_v2_z, in_v3_x, in_v3_y, in_v3_z} <= {p[6], p[7], p[8], p[9], p[10], p[11]};
    @(posedge clk iff (in_valid && in_ready));
  endtask

  // Drain, let the block settle, then write the vertex count
  task automatic set_vertices(input logic [2:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_element_vertices <= value;
    @(posedge clk iff (cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_coord(input int kind);
    case (kind)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 1) ? C_MAX : C_MIN);
      default: return $signed(32'($urandom_range(0, 2 ** 21)) - 32'sd1048576);
    endcase
  endfunction

  // Mostly small random faces, some full-range, some degenerate or at the extremes
  task automatic random_face();
    logic signed [31:0] p [12];
    int shape, kind, k;
    shape = $urandom_range(9);
    kind = (shape == 6) ? 0 : (shape == 9) ? 1 : 2;
    foreach (p[i]) p[i] = pick_coord(($urandom_range(9) == 0) ? 0 : kind);
    if (shape == 7) begin
      k = $urandom_range(1, 3);
      for (int j = 0; j < 3; j++) p[3 * k + j] = p[$urandom_range(0, 1) * 3 + j];
    end else if (shape == 8) begin
      k = $urandom_range(0, 3) - 1;
      for (int j = 0; j < 3; j++) begin
        p[3 + j] = p[j] + 32'($signed($urandom_range(0, 2000)) - 1000);
        p[6 + j] = p[j] + k * (p[3 + j] - p[j]);
        p[9 + j] = p[j] - 2 * (p[3 + j] - p[j]);
      end
    end
    send_face(p);
  endtask

  task automatic directed_faces();
    logic signed [31:0] p [12];
    logic signed [31:0] corner [5];
    corner = '{C_MIN, C_MAX, 32'sd0, -32'sd1, 32'sd1};
    // All vertices coincide
    foreach (p[i]) p[i] = 32'sd0;
    send_face(p);
    foreach (p[i]) p[i] = C_MAX;
    send_face(p);
    // Unit faces along each axis
    p = '{0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_face(p);
    p = '{0, 0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0, 32'sh10000, 0, 0};
    send_face(p);
    // Collinear points
    p = '{1, 2, 3, 2, 4, 6, 3, 6, 9, -1, -2, -3};
    send_face(p);
    // Corner values spanning the whole coordinate range
    for (int n = 0; n < 10; n++) begin
      foreach (p[i]) p[i] = corner[(i * 3 + n * 7 + i / 3) % 5];
      send_face(p);
    end
    p = '{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX};
    send_face(p);
    p = '{C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN};
    send_face(p);
  endtask

  initial begin
    logic [2:0] plan [8];
    plan = '{VERTS_ZERO, VERTS_QUAD, VERTS_SEVEN, VERTS_TRI, VERTS_QUAD, VERTS_FIVE,
             VERTS_TRI, VERTS_QUAD};
    rst_n = 1'b0;
    flow = FLOW_FREE;
    cfg_valid = 1'b0;
    cfg_element_vertices = VERTS_TRI;
    in_valid = 1'b0;
    {in_v0_x, in_v0_y, in_v0_z, in_v1_x, in_v1_y, in_v1_z} = '0;
    {in_v2_x, in_v2_y, in_v2_z, in_v3_x, in_v3_y, in_v3_z} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Triangles, then quads, at the corners of the range
    directed_faces();
    set_vertices(VERTS_QUAD);
    directed_faces();
    // Random phases over register settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      set_vertices(plan[ph]);
      flow = flow_t'(ph % 4);
      repeat (175) random_face();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("** face_normal_and_bounds_top: PASSED **");
    else
      $display("** face_normal_and_bounds_top: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/fnb_pkg.sv
rtl/fnb_mul.sv
rtl/fnb_div.sv
rtl/fnb_isqrt.sv
rtl/face_normal_and_bounds_top.sv
tb/face_normal_and_bounds_checker.sv
tb/face_normal_and_bounds_top_tb.sv
